FILE: rtl/pais_pkg.sv
// shared types and constants for the insertion array
package pais_pkg;

	localparam int DEPTH = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 6;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [1:0] {
		OP_FRONT  = 2'd0,
		OP_APPEND = 2'd1,
		OP_POS    = 2'd2,
		OP_SORTED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic signed [31:0] value;
		logic [POS_W-1:0]  position;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic signed [31:0] element;
		logic [4:0]        element_index;
		logic [5:0]        entry_count;
		logic              last;
	} rsp_t;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic               insert;
		logic               rotate;
		logic               sorted;
		logic signed [31:0] value;
		logic [CNT_W-1:0]   at;
		logic [CNT_W-1:0]   count;
	} ctl_t;

endpackage

FILE: rtl/pais_cell.sv
// one storage cell of the insertion chain
module pais_cell import pais_pkg::*; (
	input  logic                clk,
	input  logic [IDX_W-1:0]    idx,
	input  ctl_t                ctl,
	input  logic signed [31:0]  left_data,
	input  logic signed [31:0]  right_data,
	input  logic                after_in,
	output logic                after_out,
	output logic signed [31:0]  data
);

	logic signed [31:0] data_q;
	logic               hit;
	logic               occupied;

	assign occupied = {{(CNT_W-IDX_W){1'b0}}, idx} < ctl.count;

	// sorted: first occupied entry above the value, or the first free slot
	always_comb begin
		if (ctl.sorted) begin
			hit = occupied ? (data_q > ctl.value) : 1'b1;
		end else begin
			hit = ({{(CNT_W-IDX_W){1'b0}}, idx} == ctl.at);
		end
	end

	assign after_out = after_in | hit;

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (after_out) begin
				data_q <= after_in ? left_data : ctl.value;
			end
		end else if (ctl.rotate) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;

endmodule

FILE: rtl/positional_and_sorted_insert_array_top.sv
// insertion array: a chain of cells and the sequencer that drives it
// a request is taken only in the idle state; an accepted insert passes through the insert state,
//   then the emit state streams the entries, holding while the output stalls, and the spin state
//   completes the ring rotation; a rejected request gives its single result in the cycle after the beat
// no new request is taken until the full ring rotation ends and the sequencer is idle again
// reset clears the entry count and control only; the cells hold no reset value
module positional_and_sorted_insert_array_top import pais_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_INSERT = 5'b00010,
		S_EMIT   = 5'b00100,
		S_SPIN   = 5'b01000,
		S_ERR    = 5'b10000
	} state_t;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DEPTH - 1);

	state_t             state_q;
	req_t               req_q;
	logic [1:0]         err_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   rot_q;
	ctl_t               ctl;
	logic               out_last;
	logic               out_beat;
	logic               range_bad;
	logic signed [31:0] data [DEPTH];
	logic               after [DEPTH+1];

	assign range_bad = CMP_W'(req.position) > CMP_W'(count_q);
	assign out_last  = (rot_q + CNT_W'(1)) == count_q;
	assign out_beat  = rsp_valid & rsp_ready;

	always_comb begin
		ctl.insert = (state_q == S_INSERT);
		ctl.rotate = (state_q == S_SPIN) || ((state_q == S_EMIT) && rsp_ready);
		ctl.sorted = (req_q.operation == OP_SORTED);
		ctl.value  = req_q.value;
		ctl.count  = count_q;
		case (req_q.operation)
			OP_FRONT:  ctl.at = '0;
			OP_POS:    ctl.at = CNT_W'(req_q.position);
			default:   ctl.at = count_q;
		endcase
	end

	assign after[0] = 1'b0;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		pais_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(k)),
			.ctl        (ctl),
			.left_data  ((k == 0) ? req_q.value : data[(k + DEPTH - 1) % DEPTH]),
			.right_data (data[(k + 1) % DEPTH]),
			.after_in   (after[k]),
			.after_out  (after[k+1]),
			.data       (data[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rot_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (count_q == CNT_FULL) begin
							state_q <= S_ERR;
						end else if (req.operation == OP_POS && range_bad) begin
							state_q <= S_ERR;
						end else begin
							state_q <= S_INSERT;
						end
					end
				end
				S_INSERT: begin
					count_q <= count_q + CNT_W'(1);
					rot_q   <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (rsp_ready) begin
						rot_q <= rot_q + CNT_W'(1);
						if (out_last) begin
							// finish the ring so cell 0 holds entry 0 again
							state_q <= (rot_q == CNT_LAST) ? S_IDLE : S_SPIN;
						end
					end
				end
				S_SPIN: begin
					rot_q <= rot_q + CNT_W'(1);
					if (rot_q == CNT_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_ERR: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req;
			err_q <= (count_q == CNT_FULL) ? ST_FULL : ST_RANGE;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_EMIT) || (state_q == S_ERR);

	always_comb begin
		if (state_q == S_ERR) begin
			rsp.status        = err_q;
			rsp.element       = '0;
			rsp.element_index = '0;
			rsp.entry_count   = 6'(count_q);
			rsp.last          = 1'b1;
		end else begin
			rsp.status        = ST_OK;
			rsp.element       = data[0];
			rsp.element_index = 5'(rot_q);
			rsp.entry_count   = 6'(count_q);
			rsp.last          = out_last;
		end
	end

endmodule

FILE: rtl/pais_checker.sv
// port-level checks for the insertion array, bound to the top level
module pais_checker import pais_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
	else $error("result beat changed while stalled");

	// no new request while a request is being worked on
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
	else $error("request taken while busy");

	// an insert streams its entries without gaps
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp.last |=>
			rsp_valid && rsp.element_index == $past(rsp.element_index) + 5'd1)
	else $error("gap or skip in entry stream");

	// a rejected request gives a single terminal beat
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.last && rsp.element == '0)
	else $error("malformed status beat");

	// requests are held off while results are pending
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
	else $error("request ready during result stream");

endmodule

bind positional_and_sorted_insert_array_top pais_checker u_pais_checker (.*);
